// File: src/lrid_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the LZW and RLE90 image decoder.
package lrid_pkg;

    localparam int unsigned WORD_W      = 16;
    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned CFG_IDX_W   = 2;
    localparam int unsigned CFG_DATA_W  = 16;
    localparam int unsigned BUF_W       = 32;
    localparam int unsigned HELD_W      = 6;
    localparam int unsigned WIDTH_W     = 4;
    localparam int unsigned COUNT_W     = 7;
    localparam int unsigned OUT_MAX     = 64;

    localparam logic [CFG_IDX_W-1:0] REG_MAX_CODE_BITS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_BITS    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LINE_WIDTH    = 2'd2;

    localparam logic [BYTE_W-1:0]  RLE_MARK    = 8'h90;
    localparam logic [WIDTH_W-1:0] START_BITS  = 4'd9;
    localparam logic [3:0]         RST_MAX_BITS = 4'd11;
    localparam logic [15:0]        RST_LINE_WIDTH = 16'd320;
    localparam logic [HELD_W-1:0]  RST_HELD    = 6'd8;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_REPEAT,
        CMD_POP_REQ,
        CMD_POP_PROC,
        CMD_DECODE,
        CMD_WALK,
        CMD_FINISH,
        CMD_FLUSH
    } t_cmd;

    typedef struct packed {
        logic repeat_nz;
        logic stack_nz;
        logic bits_ok;
        logic count_full;
        logic dec_root;
        logic walk_root;
        logic can_emit;
        logic pop_emits;
        logic hold_valid;
        logic out_free;
    } t_status;

endpackage

// File: src/lrid_stream_if.sv
`timescale 1ns / 1ps
// Handshake channel carrying compressed stream words.
interface lrid_stream_if;
    logic        valid;
    logic        ready;
    logic [15:0] stream_word;

    modport source (output valid, output stream_word, input ready);
    modport sink (input valid, input stream_word, output ready);
endinterface

// File: src/lrid_pixel_if.sv
`timescale 1ns / 1ps
// Handshake channel carrying decoded pixel bytes.
interface lrid_pixel_if;
    logic       valid;
    logic       ready;
    logic [7:0] pixel_byte;
    logic       end_of_line;
    logic       last_of_word;

    modport source (output valid, output pixel_byte, output end_of_line,
                    output last_of_word, input ready);
    modport sink (input valid, input pixel_byte, input end_of_line,
                  input last_of_word, output ready);
endinterface

// File: src/lrid_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM with registered read data.
module lrid_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// File: src/lrid_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine that sequences decoding, stack pops and output.
module lrid_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  lrid_pkg::t_status i_status,
    output logic             o_in_ready,
    output lrid_pkg::t_cmd   o_cmd
);
    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOP,
        S_POP_D,
        S_WALK,
        S_FIN,
        S_FLUSH
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = lrid_pkg::CMD_NONE;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = i_rst_n;
                if (i_in_valid && i_rst_n) begin
                    o_cmd   = lrid_pkg::CMD_LOAD;
                    n_state = S_LOOP;
                end
            end
            S_LOOP: begin
                if (i_status.count_full) begin
                    n_state = S_FLUSH;
                end else if (i_status.repeat_nz) begin
                    if (i_status.can_emit) begin
                        o_cmd = lrid_pkg::CMD_REPEAT;
                    end
                end else if (i_status.stack_nz) begin
                    o_cmd   = lrid_pkg::CMD_POP_REQ;
                    n_state = S_POP_D;
                end else if (i_status.bits_ok) begin
                    o_cmd   = lrid_pkg::CMD_DECODE;
                    n_state = i_status.dec_root ? S_FIN : S_WALK;
                end else begin
                    n_state = S_FLUSH;
                end
            end
            S_POP_D: begin
                if (!i_status.pop_emits || i_status.can_emit) begin
                    o_cmd   = lrid_pkg::CMD_POP_PROC;
                    n_state = S_LOOP;
                end
            end
            S_WALK: begin
                o_cmd = lrid_pkg::CMD_WALK;
                if (i_status.walk_root) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                o_cmd   = lrid_pkg::CMD_FINISH;
                n_state = S_LOOP;
            end
            S_FLUSH: begin
                if (!i_status.hold_valid) begin
                    n_state = S_IDLE;
                end else if (i_status.out_free) begin
                    o_cmd   = lrid_pkg::CMD_FLUSH;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    a_walk_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK && i_status.walk_root) |=> (r_state == S_FIN))
        else $error("chain walk did not finish at a root code");
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> (o_cmd == lrid_pkg::CMD_LOAD || o_cmd == lrid_pkg::CMD_NONE))
        else $error("input taken while the datapath is busy");
    a_flush_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd == lrid_pkg::CMD_FLUSH) |=> (r_state == S_IDLE))
        else $error("flush did not end the word");
endmodule

// File: src/lrid_datapath.sv
`timescale 1ns / 1ps
// Datapath: bit buffer, code tables, expansion stack, RLE stage and output registers.
module lrid_datapath #(
    parameter int unsigned MAX_BITS = 11
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  lrid_pkg::t_cmd                      i_cmd,
    output lrid_pkg::t_status                   o_status,
    input  logic                                i_cfg_we,
    input  logic [lrid_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [lrid_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic [lrid_pkg::WORD_W-1:0]         i_word,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [lrid_pkg::BYTE_W-1:0]         o_pixel_byte,
    output logic                                o_end_of_line,
    output logic                                o_last_of_word
);
    localparam int unsigned DEPTH = 1 << MAX_BITS;
    localparam int unsigned AW    = MAX_BITS;
    localparam int unsigned CW    = MAX_BITS + 1;
    localparam logic [lrid_pkg::WIDTH_W-1:0] MAXB = lrid_pkg::WIDTH_W'(MAX_BITS);
    localparam logic [CW-1:0] FIRST_FREE = CW'(256);

    logic [lrid_pkg::BUF_W-1:0]   r_buf;
    logic [lrid_pkg::HELD_W-1:0]  r_bits;
    logic [lrid_pkg::WIDTH_W-1:0] r_width;
    logic [CW-1:0]                r_next;
    logic [AW-1:0]                r_prev;
    logic [7:0]                   r_prev_first;
    logic [7:0]                   r_rep_left;
    logic [7:0]                   r_rep_val;
    logic [15:0]                  r_col;
    logic                         r_esc;
    logic [AW-1:0]                r_cur;
    logic [AW-1:0]                r_new_prev;
    logic [AW:0]                  r_sp;
    logic [lrid_pkg::COUNT_W-1:0] r_count;
    logic [3:0]                   r_max_bits;
    logic [15:0]                  r_line_width;
    logic                         r_hold_v;
    logic [7:0]                   r_hold_byte;
    logic                         r_hold_eol;
    logic                         r_out_v;
    logic [7:0]                   r_out_byte;
    logic                         r_out_eol;
    logic                         r_out_last;

    logic [CW-1:0]  mask;
    logic [CW-1:0]  code;
    logic           kw;
    logic [AW-1:0]  dec_cur;
    logic [AW-1:0]  dec_new_prev;
    logic [CW-1:0]  next_inc;
    logic [lrid_pkg::WIDTH_W-1:0] width_inc;
    logic [lrid_pkg::WIDTH_W-1:0] limit;
    logic           tbl_clear;
    logic [AW-1:0]  pre_rd;
    logic [7:0]     suf_rd;
    logic [7:0]     stk_rd;
    logic           tbl_re;
    logic [AW-1:0]  tbl_raddr;
    logic           tbl_we;
    logic           stk_we;
    logic [AW-1:0]  stk_waddr;
    logic [7:0]     stk_wdata;
    logic           stk_re;
    logic           emit_en;
    logic [7:0]     emit_val;
    logic [15:0]    col_inc;
    logic           emit_eol;
    logic           out_free;
    logic           can_emit;
    logic           bits_ok;
    logic           pending;
    logic           out_load;

    assign mask         = (CW'(1) << r_width) - CW'(1);
    assign code         = r_buf[CW-1:0] & mask;
    assign kw           = code >= r_next;
    assign dec_cur      = kw ? r_prev : code[AW-1:0];
    assign dec_new_prev = kw ? r_next[AW-1:0] : code[AW-1:0];
    assign next_inc     = r_next + CW'(1);
    assign width_inc    = r_width + ((next_inc > mask) ? 4'd1 : 4'd0);
    assign limit        = (r_max_bits > MAXB) ? MAXB : r_max_bits;
    assign tbl_clear    = width_inc > limit;
    assign bits_ok      = r_bits >= {2'b00, r_width};
    assign pending      = (r_rep_left != 8'd0) || (r_sp != '0) || bits_ok;
    assign out_free     = !r_out_v || i_out_ready;
    assign can_emit     = !r_hold_v || out_free;
    assign col_inc      = r_col + 16'd1;
    assign emit_eol     = col_inc == r_line_width;

    always_comb begin
        tbl_re    = 1'b0;
        tbl_raddr = dec_cur;
        stk_we    = 1'b0;
        stk_wdata = r_prev_first;
        stk_re    = 1'b0;
        emit_en   = 1'b0;
        emit_val  = r_rep_val;
        case (i_cmd)
            lrid_pkg::CMD_DECODE: begin
                tbl_re = dec_cur[AW-1:8] != '0;
                stk_we = kw;
            end
            lrid_pkg::CMD_WALK: begin
                tbl_re    = pre_rd[AW-1:8] != '0;
                tbl_raddr = pre_rd;
                stk_we    = 1'b1;
                stk_wdata = suf_rd;
            end
            lrid_pkg::CMD_FINISH: begin
                stk_we    = 1'b1;
                stk_wdata = r_cur[7:0];
            end
            lrid_pkg::CMD_POP_REQ: stk_re = 1'b1;
            lrid_pkg::CMD_REPEAT: emit_en = 1'b1;
            lrid_pkg::CMD_POP_PROC: begin
                if (r_esc) begin
                    emit_en  = stk_rd == 8'd0;
                    emit_val = lrid_pkg::RLE_MARK;
                end else begin
                    emit_en  = stk_rd != lrid_pkg::RLE_MARK;
                    emit_val = stk_rd;
                end
            end
            default: ;
        endcase
    end

    assign tbl_we    = (i_cmd == lrid_pkg::CMD_FINISH) && !r_next[CW-1];
    assign stk_waddr = r_sp[AW-1:0];
    assign out_load  = (i_cmd == lrid_pkg::CMD_FLUSH) || (emit_en && r_hold_v);

    lrid_ram #(.WIDTH(AW), .DEPTH(DEPTH)) u_prefix (
        .i_clk   (i_clk),
        .i_we    (tbl_we),
        .i_waddr (r_next[AW-1:0]),
        .i_wdata (r_prev),
        .i_re    (tbl_re),
        .i_raddr (tbl_raddr),
        .o_rdata (pre_rd)
    );

    lrid_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_suffix (
        .i_clk   (i_clk),
        .i_we    (tbl_we),
        .i_waddr (r_next[AW-1:0]),
        .i_wdata (r_cur[7:0]),
        .i_re    (tbl_re),
        .i_raddr (tbl_raddr),
        .o_rdata (suf_rd)
    );

    lrid_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_stack (
        .i_clk   (i_clk),
        .i_we    (stk_we),
        .i_waddr (stk_waddr),
        .i_wdata (stk_wdata),
        .i_re    (stk_re),
        .i_raddr (stk_waddr - AW'(1)),
        .o_rdata (stk_rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buf        <= '0;
            r_bits       <= lrid_pkg::RST_HELD;
            r_width      <= lrid_pkg::START_BITS;
            r_next       <= FIRST_FREE;
            r_prev       <= '0;
            r_prev_first <= '0;
            r_rep_left   <= '0;
            r_rep_val    <= '0;
            r_col        <= '0;
            r_esc        <= 1'b0;
            r_sp         <= '0;
            r_count      <= '0;
            r_max_bits   <= lrid_pkg::RST_MAX_BITS;
            r_line_width <= lrid_pkg::RST_LINE_WIDTH;
            r_hold_v     <= 1'b0;
            r_out_v      <= 1'b0;
        end else begin
            if (out_load) begin
                r_out_v <= 1'b1;
            end else if (r_out_v && i_out_ready) begin
                r_out_v <= 1'b0;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    lrid_pkg::REG_MAX_CODE_BITS: r_max_bits <= i_cfg_data[3:0];
                    lrid_pkg::REG_FIRST_BITS: begin
                        r_buf  <= {24'd0, i_cfg_data[7:0]};
                        r_bits <= lrid_pkg::RST_HELD;
                    end
                    lrid_pkg::REG_LINE_WIDTH: r_line_width <= i_cfg_data;
                    default: ;
                endcase
            end
            if (stk_we && !r_sp[AW]) begin
                r_sp <= r_sp + (AW+1)'(1);
            end
            case (i_cmd)
                lrid_pkg::CMD_LOAD: begin
                    r_count <= '0;
                    if (r_bits <= 6'd16) begin
                        r_buf  <= r_buf | ({16'd0, i_word} << r_bits[4:0]);
                        r_bits <= r_bits + 6'd16;
                    end
                end
                lrid_pkg::CMD_REPEAT: r_rep_left <= r_rep_left - 8'd1;
                lrid_pkg::CMD_POP_REQ: r_sp <= r_sp - (AW+1)'(1);
                lrid_pkg::CMD_POP_PROC: begin
                    if (r_esc) begin
                        r_esc <= 1'b0;
                        if (stk_rd != 8'd0) begin
                            r_rep_left <= stk_rd - 8'd1;
                        end else begin
                            r_rep_val <= lrid_pkg::RLE_MARK;
                        end
                    end else if (stk_rd == lrid_pkg::RLE_MARK) begin
                        r_esc <= 1'b1;
                    end else begin
                        r_rep_val <= stk_rd;
                    end
                end
                lrid_pkg::CMD_DECODE: begin
                    r_buf      <= r_buf >> r_width;
                    r_bits     <= r_bits - {2'b00, r_width};
                    r_cur      <= dec_cur;
                    r_new_prev <= dec_new_prev;
                end
                lrid_pkg::CMD_WALK: r_cur <= pre_rd;
                lrid_pkg::CMD_FINISH: begin
                    r_prev_first <= r_cur[7:0];
                    if (tbl_clear) begin
                        r_width <= lrid_pkg::START_BITS;
                        r_next  <= FIRST_FREE;
                        r_prev  <= '0;
                    end else begin
                        r_width <= width_inc;
                        r_next  <= next_inc;
                        r_prev  <= r_new_prev;
                    end
                end
                lrid_pkg::CMD_FLUSH: begin
                    r_hold_v   <= 1'b0;
                    r_out_byte <= r_hold_byte;
                    r_out_eol  <= r_hold_eol;
                    r_out_last <= !pending;
                end
                default: ;
            endcase
            if (emit_en) begin
                if (r_hold_v) begin
                    r_out_byte <= r_hold_byte;
                    r_out_eol  <= r_hold_eol;
                    r_out_last <= 1'b0;
                end
                r_hold_v    <= 1'b1;
                r_hold_byte <= emit_val;
                r_hold_eol  <= emit_eol;
                r_col       <= emit_eol ? 16'd0 : col_inc;
                r_count     <= r_count + lrid_pkg::COUNT_W'(1);
            end
        end
    end

    assign o_status.repeat_nz  = r_rep_left != 8'd0;
    assign o_status.stack_nz   = r_sp != '0;
    assign o_status.bits_ok    = bits_ok;
    assign o_status.count_full = r_count == lrid_pkg::COUNT_W'(lrid_pkg::OUT_MAX);
    assign o_status.dec_root   = dec_cur[AW-1:8] == '0;
    assign o_status.walk_root  = pre_rd[AW-1:8] == '0;
    assign o_status.can_emit   = can_emit;
    assign o_status.pop_emits  = r_esc ? (stk_rd == 8'd0) : (stk_rd != lrid_pkg::RLE_MARK);
    assign o_status.hold_valid = r_hold_v;
    assign o_status.out_free   = out_free;

    assign o_out_valid    = r_out_v;
    assign o_pixel_byte   = r_out_byte;
    assign o_end_of_line  = r_out_eol;
    assign o_last_of_word = r_out_last;

    a_bits_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bits <= 6'd32)
        else $error("bit buffer overfilled");
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit_en |-> (r_count < lrid_pkg::COUNT_W'(lrid_pkg::OUT_MAX)))
        else $error("more than the word limit of pixels");
    a_emit_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit_en && r_hold_v) |-> out_free)
        else $error("pixel emitted while the output register is blocked");
    a_width_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd == lrid_pkg::CMD_DECODE) |-> (r_width <= MAXB))
        else $error("code width above the table size");
endmodule

// File: src/lzw_rle90_image_decoder.sv
`timescale 1ns / 1ps
// Top level of the LZW decoder with RLE90 expansion for image data.
//
//  channel    | dir | payload                                  | handshake
//  i_stream   | in  | stream_word[15:0]                        | valid/ready
//  o_pixel    | out | pixel_byte[7:0], end_of_line, last_of_word | valid/ready
//  i_cfg_*    | in  | i_cfg_index[1:0], i_cfg_data[15:0]       | i_cfg_we
//
// After a word is loaded, repeats, stack pops (request, process) and codes (decode, a walk
// over non-root entries, finish) run in turn, the walk reading the tables once a cycle.
// Reset is synchronous; tables need no clearing pass, and a word can be taken as soon
// as reset is released. Output stalls hold the sequencer at the next pixel; no word is
// taken until every pixel of the previous word has left the holding stage.
module lzw_rle90_image_decoder #(
    parameter int unsigned MAX_BITS = 11
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [lrid_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [lrid_pkg::CFG_DATA_W-1:0] i_cfg_data,
    lrid_stream_if.sink                     i_stream,
    lrid_pixel_if.source                    o_pixel
);
    lrid_pkg::t_cmd    cmd;
    lrid_pkg::t_status status;

    lrid_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_stream.valid),
        .i_status   (status),
        .o_in_ready (i_stream.ready),
        .o_cmd      (cmd)
    );

    lrid_datapath #(.MAX_BITS(MAX_BITS)) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_word         (i_stream.stream_word),
        .o_out_valid    (o_pixel.valid),
        .i_out_ready    (o_pixel.ready),
        .o_pixel_byte   (o_pixel.pixel_byte),
        .o_end_of_line  (o_pixel.end_of_line),
        .o_last_of_word (o_pixel.last_of_word)
    );
endmodule
